// ===== design/ddm_pkg.sv =====
// ddm_pkg: shared types, constants and register codes for the differential drive mixer
// no dependencies; used by every module of the mixer by scoped names

package ddm_pkg;

    // default half scale of the wheel range (centre value)
    localparam int HALF_SCALE_DEF = 250;

    // register reset values
    localparam logic [5:0]  TURN_GAIN_RST     = 6'd16;
    localparam logic [11:0] DUTY_OFFSET_RST   = 12'd1750;
    localparam logic [11:0] BRAKE_COMPARE_RST = 12'd2000;

    // largest compare value
    localparam logic [11:0] COMPARE_MAX = 12'hFFF;

    // configuration register codes (word address paddr[3:2])
    typedef enum logic [1:0] {
        REG_TURN_GAIN     = 2'd0,
        REG_DUTY_OFFSET   = 2'd1,
        REG_BRAKE_COMPARE = 2'd2
    } ddm_reg_t;

    // input command word
    typedef struct packed {
        logic [7:0] speed_magnitude;
        logic       speed_forward;
        logic [7:0] turn_amount;
        logic       turn_right;
    } ddm_in_t;

    // result word
    typedef struct packed {
        logic [7:0]  left_drive;
        logic        left_direction;
        logic [7:0]  right_drive;
        logic        right_direction;
        logic [11:0] left_compare;
        logic        left_fwd_pin;
        logic        left_rev_pin;
        logic [11:0] right_compare;
        logic        right_fwd_pin;
        logic        right_rev_pin;
    } ddm_out_t;

    // per-wheel drive result
    typedef struct packed {
        logic [7:0]  duty;
        logic        direction;
        logic [11:0] compare;
        logic        fwd_pin;
        logic        rev_pin;
    } ddm_side_t;

endpackage

// ===== design/differential_drive_mixer_pwm.sv =====
// differential_drive_mixer_pwm: top level with register port, input and result registers
// depends on ddm_pkg, ddm_mixer, ddm_side

// Differential drive mixer: each command word (speed magnitude and direction, turn
// magnitude and direction) yields one result word with both wheels' duty, direction,
// timer compare value and drive pin levels. An accepted word sits in the input register,
// and its result is loaded into the result register once that register is empty or taken,
// which raises m_valid. The work between the two registers is one 8x6 multiply, a few adds
// and clamps per wheel, so the block takes one word per cycle whenever the result side
// keeps taking words. Registers (turn_gain at 0x0, duty_offset at 0x4, brake_compare at
// 0x8) must be written only while the block is idle, which the block itself does not
// enforce; each write applies to every word after that.

module differential_drive_mixer_pwm #(
    parameter int HALF_SCALE = ddm_pkg::HALF_SCALE_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    // command channel
    input  logic              s_valid,
    output logic              s_ready,
    input  ddm_pkg::ddm_in_t  s_data,
    // result channel
    output logic              m_valid,
    input  logic              m_ready,
    output ddm_pkg::ddm_out_t m_data,
    // register port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int OW = $clog2(2 * HALF_SCALE + 1);

    logic [5:0]         turn_gain_reg;
    logic [11:0]        duty_offset_reg;
    logic [11:0]        brake_compare_reg;
    logic               cfg_write;

    logic               in_valid_reg;
    ddm_pkg::ddm_in_t   in_data_reg;
    logic               out_valid_reg;
    ddm_pkg::ddm_out_t  out_data_reg;
    ddm_pkg::ddm_out_t  out_data_next;
    logic               advance;

    logic [OW-1:0]      left_value;
    logic [OW-1:0]      right_value;
    ddm_pkg::ddm_side_t left_side;
    ddm_pkg::ddm_side_t right_side;

    // register write
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            turn_gain_reg     <= ddm_pkg::TURN_GAIN_RST;
            duty_offset_reg   <= ddm_pkg::DUTY_OFFSET_RST;
            brake_compare_reg <= ddm_pkg::BRAKE_COMPARE_RST;
        end else if (cfg_write) begin
            case (paddr[3:2])
                ddm_pkg::REG_TURN_GAIN:     turn_gain_reg     <= pwdata[5:0];
                ddm_pkg::REG_DUTY_OFFSET:   duty_offset_reg   <= pwdata[11:0];
                ddm_pkg::REG_BRAKE_COMPARE: brake_compare_reg <= pwdata[11:0];
                default: ;
            endcase
        end
    end

    // register read
    always_comb begin
        case (paddr[3:2])
            ddm_pkg::REG_TURN_GAIN:     prdata = {26'd0, turn_gain_reg};
            ddm_pkg::REG_DUTY_OFFSET:   prdata = {20'd0, duty_offset_reg};
            ddm_pkg::REG_BRAKE_COMPARE: prdata = {20'd0, brake_compare_reg};
            default:                    prdata = 32'd0;
        endcase
    end

    // pipeline flow: result stage moves when empty or taken
    assign advance = ~out_valid_reg | m_ready;
    assign s_ready = ~in_valid_reg | advance;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready & s_valid) begin
            in_data_reg <= s_data;
        end
    end

    // mixing and per-wheel drive
    ddm_mixer #(
        .HALF_SCALE(HALF_SCALE)
    ) u_mixer (
        .cmd        (in_data_reg),
        .turn_gain  (turn_gain_reg),
        .left_value (left_value),
        .right_value(right_value)
    );

    ddm_side #(
        .HALF_SCALE(HALF_SCALE)
    ) u_left (
        .value        (left_value),
        .duty_offset  (duty_offset_reg),
        .brake_compare(brake_compare_reg),
        .side         (left_side)
    );

    ddm_side #(
        .HALF_SCALE(HALF_SCALE)
    ) u_right (
        .value        (right_value),
        .duty_offset  (duty_offset_reg),
        .brake_compare(brake_compare_reg),
        .side         (right_side)
    );

    // result word assembly
    always_comb begin
        out_data_next.left_drive      = left_side.duty;
        out_data_next.left_direction  = left_side.direction;
        out_data_next.right_drive     = right_side.duty;
        out_data_next.right_direction = right_side.direction;
        out_data_next.left_compare    = left_side.compare;
        out_data_next.left_fwd_pin    = left_side.fwd_pin;
        out_data_next.left_rev_pin    = left_side.rev_pin;
        out_data_next.right_compare   = right_side.compare;
        out_data_next.right_fwd_pin   = right_side.fwd_pin;
        out_data_next.right_rev_pin   = right_side.rev_pin;
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance & in_valid_reg) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

// ===== design/ddm_mixer.sv =====
// ddm_mixer: arcade mixing of speed and turn into clamped left and right wheel values
// depends on ddm_pkg (input word type)

module ddm_mixer #(
    parameter int HALF_SCALE = ddm_pkg::HALF_SCALE_DEF,
    localparam int FULL = 2 * HALF_SCALE,
    localparam int OW   = $clog2(FULL + 1)
) (
    input  ddm_pkg::ddm_in_t cmd,
    input  logic [5:0]       turn_gain,
    output logic [OW-1:0]    left_value,
    output logic [OW-1:0]    right_value
);

    // working width holds centre plus unsaturated turn with sign
    localparam int VW = $clog2(4 * HALF_SCALE + 1024) + 1;
    localparam logic signed [VW-1:0] HALF_V = VW'(HALF_SCALE);
    localparam logic signed [VW-1:0] FULL_V = VW'(FULL);

    logic [13:0]          product;
    logic signed [VW-1:0] mag;
    logic signed [VW-1:0] turn_raw;
    logic signed [VW-1:0] turn;
    logic signed [VW-1:0] centre;
    logic signed [VW-1:0] fast_raw;
    logic signed [VW-1:0] slow_raw;
    logic signed [VW-1:0] fast;
    logic signed [VW-1:0] slow;
    logic [OW-1:0]        fast_v;
    logic [OW-1:0]        slow_v;

    // speed saturated to half scale and centred
    always_comb begin
        mag = $signed(VW'(cmd.speed_magnitude));
        if (mag > HALF_V) begin
            mag = HALF_V;
        end
        centre = cmd.speed_forward ? (HALF_V + mag) : (HALF_V - mag);
    end

    // turn term: magnitude times gain in sixteenths, saturated at full scale
    always_comb begin
        product  = 14'(cmd.turn_amount) * 14'(turn_gain);
        turn_raw = $signed(VW'(product[13:4]));
        turn     = (turn_raw > FULL_V) ? FULL_V : turn_raw;
    end

    // fast and slow wheels, pair shifted back into range
    always_comb begin
        fast_raw = centre + turn;
        slow_raw = centre - turn;
        if (fast_raw > FULL_V) begin
            fast = FULL_V;
            slow = FULL_V - turn;
        end else if (slow_raw < 0) begin
            fast = turn;
            slow = '0;
        end else begin
            fast = fast_raw;
            slow = slow_raw;
        end
        fast_v = OW'(fast);
        slow_v = OW'(slow);
    end

    // turn direction picks the slow side
    assign left_value  = cmd.turn_right ? fast_v : slow_v;
    assign right_value = cmd.turn_right ? slow_v : fast_v;

endmodule

// ===== design/ddm_side.sv =====
// ddm_side: one wheel's duty, direction, timer compare and drive pins
// depends on ddm_pkg (side result type, compare limit)

module ddm_side #(
    parameter int HALF_SCALE = ddm_pkg::HALF_SCALE_DEF,
    localparam int OW = $clog2(2 * HALF_SCALE + 1)
) (
    input  logic [OW-1:0]      value,
    input  logic [11:0]        duty_offset,
    input  logic [11:0]        brake_compare,
    output ddm_pkg::ddm_side_t side
);

    localparam int DW = OW + 1;
    localparam logic signed [DW-1:0] HALF_V = DW'(HALF_SCALE);

    logic signed [DW-1:0] delta;
    logic [DW-1:0]        delta_abs;
    logic [7:0]           duty;
    logic                 up;
    logic                 active;
    logic [12:0]          sum;

    // distance from centre, duty keeps the low eight bits
    always_comb begin
        delta     = $signed({1'b0, value}) - HALF_V;
        up        = delta > 0;
        delta_abs = (delta < 0) ? DW'(-delta) : DW'(delta);
        duty      = 8'(delta_abs);
        active    = duty != 8'd0;
    end

    // compare: offset plus duty, saturated; brake value for zero duty
    always_comb begin
        sum = {1'b0, duty_offset} + 13'(duty);
        side.duty      = duty;
        side.direction = up;
        if (!active) begin
            side.compare = brake_compare;
        end else if (sum[12]) begin
            side.compare = ddm_pkg::COMPARE_MAX;
        end else begin
            side.compare = sum[11:0];
        end
        side.fwd_pin = active & up;
        side.rev_pin = active & ~up;
    end

endmodule

// ===== bench/tb_top.sv =====
// tb_top: self-checking bench for differential_drive_mixer_pwm, with word-level prediction
// depends on ddm_pkg and the differential_drive_mixer_pwm design files

module tb_top;

    localparam int HALF         = ddm_pkg::HALF_SCALE_DEF;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASES       = 8;
    localparam int PHASE_WORDS  = 230;
    localparam int PRINT_CAP    = 50;

    // typed-in results under reset register values
    localparam ddm_pkg::ddm_out_t IDLE_BOTH = {8'd0, 1'b0, 8'd0, 1'b0,
                                      12'd2000, 1'b0, 1'b0, 12'd2000, 1'b0, 1'b0};
    localparam ddm_pkg::ddm_out_t FULL_FWD  = {8'd250, 1'b1, 8'd250, 1'b1,
                                      12'd2000, 1'b1, 1'b0, 12'd2000, 1'b1, 1'b0};
    localparam ddm_pkg::ddm_out_t FULL_REV  = {8'd250, 1'b0, 8'd250, 1'b0,
                                      12'd2000, 1'b0, 1'b1, 12'd2000, 1'b0, 1'b1};
    localparam ddm_pkg::ddm_out_t NO_WANT   = '0;

    // directed row: command, typed flag, typed result
    typedef struct packed {
        ddm_pkg::ddm_in_t  cmd;
        logic              typed;
        ddm_pkg::ddm_out_t want;
    } cmd_row_t;

    localparam int DIRECTED_N = 18;
    localparam cmd_row_t DIRECTED_ROWS [DIRECTED_N] = '{
        {8'd0,   1'b1, 8'd0,   1'b0, 1'b1, IDLE_BOTH},  // standstill
        {8'd0,   1'b0, 8'd0,   1'b1, 1'b1, IDLE_BOTH},
        {8'd250, 1'b1, 8'd0,   1'b0, 1'b1, FULL_FWD},   // full forward
        {8'd255, 1'b1, 8'd0,   1'b1, 1'b1, FULL_FWD},   // speed above half scale
        {8'd250, 1'b0, 8'd0,   1'b0, 1'b1, FULL_REV},   // full reverse
        {8'd255, 1'b0, 8'd0,   1'b1, 1'b1, FULL_REV},
        {8'd0,   1'b1, 8'd250, 1'b0, 1'b0, NO_WANT},    // spin in place
        {8'd0,   1'b1, 8'd250, 1'b1, 1'b0, NO_WANT},
        {8'd250, 1'b1, 8'd250, 1'b0, 1'b0, NO_WANT},    // fast side past full
        {8'd250, 1'b0, 8'd250, 1'b1, 1'b0, NO_WANT},    // slow side below zero
        {8'd255, 1'b1, 8'd255, 1'b1, 1'b0, NO_WANT},
        {8'd1,   1'b1, 8'd0,   1'b0, 1'b0, NO_WANT},
        {8'd1,   1'b0, 8'd1,   1'b1, 1'b0, NO_WANT},
        {8'd0,   1'b0, 8'd1,   1'b0, 1'b0, NO_WANT},
        {8'd128, 1'b1, 8'd127, 1'b0, 1'b0, NO_WANT},
        {8'd127, 1'b0, 8'd128, 1'b1, 1'b0, NO_WANT},
        {8'd85,  1'b1, 8'd170, 1'b1, 1'b0, NO_WANT},
        {8'd170, 1'b0, 8'd85,  1'b0, 1'b0, NO_WANT}
    };

    logic              aclk    = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    ddm_pkg::ddm_in_t  s_data  = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    ddm_pkg::ddm_out_t m_data;
    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [3:0]        paddr   = '0;
    logic [31:0]       pwdata  = '0;
    logic [31:0]       prdata;
    logic              pready;

    // register shadow
    logic [5:0]  gain_reg   = ddm_pkg::TURN_GAIN_RST;
    logic [11:0] offset_reg = ddm_pkg::DUTY_OFFSET_RST;
    logic [11:0] brake_reg  = ddm_pkg::BRAKE_COMPARE_RST;

    // typed result riding along with the word on the command channel
    logic              want_typed = 1'b0;
    ddm_pkg::ddm_out_t want_word  = '0;

    ddm_pkg::ddm_out_t pending_results [$];
    int          err_count    = 0;
    int          result_count = 0;
    int          cycle_count  = 0;
    int          gap_pct      = 0;
    int          stall_pct    = 0;
    int          stall_left   = 0;

    differential_drive_mixer_pwm DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycle_count, pending_results.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic report_mismatch(string what, int got, int want);
        err_count++;
        if (err_count <= PRINT_CAP)
            $display("result %0d: %s got %0d expected %0d", result_count, what, got, want);
    endtask

    // one wheel: distance from center gives duty, sign gives direction
    function automatic ddm_pkg::ddm_side_t wheel_drive(int value);
        ddm_pkg::ddm_side_t side;
        int        delta;
        int        cmp;
        logic      up;
        delta          = value - HALF;
        up             = (delta > 0);
        side.duty      = 8'(delta < 0 ? -delta : delta);
        side.direction = up;
        if (side.duty == 8'd0) begin
            side.compare = brake_reg;
            side.fwd_pin = 1'b0;
            side.rev_pin = 1'b0;
        end else begin
            cmp          = int'(offset_reg) + int'(side.duty);
            side.compare = (cmp > 4095) ? ddm_pkg::COMPARE_MAX : 12'(cmp);
            side.fwd_pin = up;
            side.rev_pin = !up;
        end
        return side;
    endfunction

    // arcade mix of speed and turn into left and right wheel drive
    function automatic ddm_pkg::ddm_out_t mix_predict(ddm_pkg::ddm_in_t cmd);
        ddm_pkg::ddm_out_t  res;
        ddm_pkg::ddm_side_t lhs;
        ddm_pkg::ddm_side_t rhs;
        int        mag;
        int        tmag;
        int        centre;
        int        turn;
        int        fast;
        int        slow;
        mag    = cmd.speed_magnitude;
        tmag   = cmd.turn_amount;
        if (mag > HALF) mag = HALF;
        centre = cmd.speed_forward ? HALF + mag : HALF - mag;
        turn   = (tmag * int'(gain_reg)) / 16;
        if (turn > 2 * HALF) turn = 2 * HALF;
        fast   = centre + turn;
        slow   = centre - turn;
        if (fast > 2 * HALF) begin
            fast = 2 * HALF;
            slow = 2 * HALF - turn;
        end else if (slow < 0) begin
            slow = 0;
            fast = turn;
        end
        lhs = wheel_drive(cmd.turn_right ? fast : slow);
        rhs = wheel_drive(cmd.turn_right ? slow : fast);
        res.left_drive      = lhs.duty;
        res.left_direction  = lhs.direction;
        res.left_compare    = lhs.compare;
        res.left_fwd_pin    = lhs.fwd_pin;
        res.left_rev_pin    = lhs.rev_pin;
        res.right_drive     = rhs.duty;
        res.right_direction = rhs.direction;
        res.right_compare   = rhs.compare;
        res.right_fwd_pin   = rhs.fwd_pin;
        res.right_rev_pin   = rhs.rev_pin;
        return res;
    endfunction

    task automatic check_word(ddm_pkg::ddm_out_t got, ddm_pkg::ddm_out_t want);
        if (got.left_drive !== want.left_drive)
            report_mismatch("left_drive", got.left_drive, want.left_drive);
        if (got.left_direction !== want.left_direction)
            report_mismatch("left_direction", got.left_direction, want.left_direction);
        if (got.right_drive !== want.right_drive)
            report_mismatch("right_drive", got.right_drive, want.right_drive);
        if (got.right_direction !== want.right_direction)
            report_mismatch("right_direction", got.right_direction, want.right_direction);
        if (got.left_compare !== want.left_compare)
            report_mismatch("left_compare", got.left_compare, want.left_compare);
        if (got.left_fwd_pin !== want.left_fwd_pin)
            report_mismatch("left_fwd_pin", got.left_fwd_pin, want.left_fwd_pin);
        if (got.left_rev_pin !== want.left_rev_pin)
            report_mismatch("left_rev_pin", got.left_rev_pin, want.left_rev_pin);
        if (got.right_compare !== want.right_compare)
            report_mismatch("right_compare", got.right_compare, want.right_compare);
        if (got.right_fwd_pin !== want.right_fwd_pin)
            report_mismatch("right_fwd_pin", got.right_fwd_pin, want.right_fwd_pin);
        if (got.right_rev_pin !== want.right_rev_pin)
            report_mismatch("right_rev_pin", got.right_rev_pin, want.right_rev_pin);
    endtask

    // accepted commands queue their result; accepted results are checked in order
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                pending_results.push_back(want_typed ? want_word : mix_predict(s_data));
            if (m_valid && m_ready) begin
                result_count++;
                if (pending_results.size() == 0)
                    report_mismatch("result with nothing pending", 1, 0);
                else
                    check_word(m_data, pending_results.pop_front());
            end
        end
    end

    // result side back-pressure in random bursts
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
            stall_left = $urandom_range(1, 6) - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic reg_write(ddm_pkg::ddm_reg_t idx, logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            ddm_pkg::REG_TURN_GAIN:     gain_reg   = val[5:0];
            ddm_pkg::REG_DUTY_OFFSET:   offset_reg = val[11:0];
            ddm_pkg::REG_BRAKE_COMPARE: brake_reg  = val[11:0];
            default: ;
        endcase
        // bus idle between transfers
        @(posedge aclk);
    endtask

    // read back and compare the implemented bits
    task automatic reg_check(ddm_pkg::ddm_reg_t idx);
        logic [11:0] want;
        logic [11:0] mask;
        case (idx)
            ddm_pkg::REG_TURN_GAIN:   begin want = {6'd0, gain_reg}; mask = 12'h03F; end
            ddm_pkg::REG_DUTY_OFFSET: begin want = offset_reg;       mask = 12'hFFF; end
            default:                  begin want = brake_reg;        mask = 12'hFFF; end
        endcase
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if ((prdata[11:0] & mask) !== want)
            report_mismatch("register readback", prdata[11:0] & mask, want);
        psel    <= 1'b0;
        penable <= 1'b0;
        // bus idle between transfers
        @(posedge aclk);
    endtask

    task automatic send_cmd(ddm_pkg::ddm_in_t cmd, logic typed, ddm_pkg::ddm_out_t want);
        if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        want_typed <= typed;
        want_word  <= want;
        s_valid    <= 1'b1;
        s_data     <= cmd;
        do @(posedge aclk); while (!s_ready);
    endtask

    // hold off the command side until every pending result is back
    task automatic drain_results();
        s_valid <= 1'b0;
        // let the last accepted word reach the queue first
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // magnitude with weight on the ends and on the out-of-range codes
    function automatic logic [7:0] rand_mag();
        case ($urandom_range(0, 9))
            0:       return 8'd0;
            1:       return 8'd250;
            2:       return 8'($urandom_range(251, 255));
            3:       return 8'($urandom_range(240, 250));
            4:       return 8'($urandom_range(1, 10));
            default: return 8'($urandom_range(0, 250));
        endcase
    endfunction

    initial begin
        ddm_pkg::ddm_in_t cmd;
        logic [31:0] gain_val;
        logic [31:0] offset_val;
        logic [31:0] brake_val;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset values, then the directed table
        reg_check(ddm_pkg::REG_TURN_GAIN);
        reg_check(ddm_pkg::REG_DUTY_OFFSET);
        reg_check(ddm_pkg::REG_BRAKE_COMPARE);
        gap_pct   = 30;
        stall_pct = 30;
        for (int i = 0; i < DIRECTED_N; i++)
            send_cmd(DIRECTED_ROWS[i].cmd, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);

        // random phases, each under its own register setting
        for (int p = 0; p < PHASES; p++) begin
            drain_results();
            case (p)
                0:       begin gain_val = 0;  offset_val = 0;    brake_val = 0;    end
                1:       begin gain_val = 63; offset_val = 4095; brake_val = 4095; end
                2:       begin gain_val = 32; offset_val = 4000; brake_val = 1;    end
                3:       begin gain_val = 1;  offset_val = 2345; brake_val = 4094; end
                4:       begin gain_val = 16; offset_val = 1750; brake_val = 2000; end
                default: begin
                    gain_val   = $urandom_range(0, 63);
                    offset_val = $urandom_range(0, 4095);
                    brake_val  = $urandom_range(0, 4095);
                end
            endcase
            // junk in the unused upper bits
            reg_write(ddm_pkg::REG_TURN_GAIN,     {$urandom} & ~32'h3F | gain_val);
            reg_write(ddm_pkg::REG_DUTY_OFFSET,   {$urandom} & ~32'hFFF | offset_val);
            reg_write(ddm_pkg::REG_BRAKE_COMPARE, {$urandom} & ~32'hFFF | brake_val);
            reg_check(ddm_pkg::REG_TURN_GAIN);
            reg_check(ddm_pkg::REG_DUTY_OFFSET);
            reg_check(ddm_pkg::REG_BRAKE_COMPARE);

            // one phase without idling in the middle, none at the end
            if (p == 3 || p == PHASES - 1) begin
                gap_pct   = 0;
                stall_pct = 0;
            end else begin
                gap_pct   = $urandom_range(10, 50);
                stall_pct = $urandom_range(10, 50);
            end
            for (int i = 0; i < PHASE_WORDS; i++) begin
                cmd.speed_magnitude = rand_mag();
                cmd.speed_forward   = 1'($urandom_range(0, 1));
                cmd.turn_amount     = rand_mag();
                cmd.turn_right      = 1'($urandom_range(0, 1));
                send_cmd(cmd, 1'b0, NO_WANT);
            end
        end

        drain_results();
        repeat (10) @(posedge aclk);
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== files.f =====
design/ddm_pkg.sv
design/ddm_mixer.sv
design/ddm_side.sv
design/differential_drive_mixer_pwm.sv
bench/tb_top.sv
